>>> hw/rtl/fat12_cluster_table_engine_defines.svh
// assertion macros for the fat12 cluster table engine
// expects clk and rst in the scope of each use; empty bodies when SYNTH is set
`ifndef FAT12_CLUSTER_TABLE_ENGINE_DEFINES_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define FCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define FCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FCT_ASSERT_IMP(lbl, ante, cons, msg)
`define FCT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/fat12_pkg.sv
// shared types, constants and entry codec function for the fat12 cluster table
// no dependencies
package fat12_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 13;
  localparam int ENTRY_W     = 16;

  localparam logic [CNT_W-1:0]   DEPTH_CNT    = CNT_W'(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0]  LAST_ADDR    = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]   COUNT_RESET  = 13'd4096;
  localparam logic [CNT_W-1:0]   FIRST_DATA   = 13'd2;
  localparam logic [11:0]        MARK_LIMIT   = 12'hFF0;
  localparam logic [ENTRY_W-1:0] MARK_WIDEN   = 16'hF000;
  localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 16'hFFFF;
  localparam logic [ENTRY_W-1:0] USED_LOW     = 16'h0002;
  localparam logic [ENTRY_W-1:0] USED_HIGH    = 16'hFFEF;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_ALLOC  = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_t;

  // one write request into the table memory
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [ENTRY_W-1:0]  data;
  } tbl_wr_t;

  // fat12 entry to 16 bits, marks move up to the fat16 range
  function automatic logic [ENTRY_W-1:0] widen_entry(input logic [11:0] v12);
    logic [ENTRY_W-1:0] v;
    v = {4'h0, v12};
    if (v12 >= MARK_LIMIT) begin
      v = v + MARK_WIDEN;
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/fat12_table.sv
// cluster table storage: one write port, one read port, registered read data
// depends on fat12_pkg
module fat12_table (
  input  logic                          clk,
  input  fat12_pkg::tbl_wr_t            wr,
  input  logic [fat12_pkg::ADDR_W-1:0]  rd_addr,
  output logic [fat12_pkg::ENTRY_W-1:0] rd_data
);

  logic [fat12_pkg::ENTRY_W-1:0] mem [fat12_pkg::TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/fat12_cluster_table_engine.sv
// fat12 cluster table engine: load, lookup, allocate and dump on a 4096 x 16 table
// allocate scans from cluster 2 for a free entry and marks it end of chain
// one item at a time, taken only in idle; the scan reads one entry per cycle
// reset (rst, synchronous) clears all 4096 entries in one pass; no item is taken meanwhile
// depends on fat12_pkg, fat12_table and fat12_cluster_table_engine_defines.svh
`include "fat12_cluster_table_engine_defines.svh"
module fat12_cluster_table_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [11:0] entry_index,
  input  logic [15:0] prev_cluster,
  input  logic [23:0] packed_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] entry_value,
  output logic [23:0] packed_out,
  output logic        table_full
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD2,
    S_LOOK,
    S_DUMP1,
    S_DUMP2,
    S_SCAN,
    S_LINK,
    S_DONE
  } state_t;

  state_t state;

  logic [fat12_pkg::CNT_W-1:0]   used_count;
  logic [fat12_pkg::ADDR_W-1:0]  clr;
  logic [fat12_pkg::CNT_W-1:0]   chk;
  logic [fat12_pkg::CNT_W-1:0]   lim_q;
  logic [11:0]                   idx_q;
  logic [15:0]                   prev_q;
  logic [11:0]                   hi_q;
  logic [11:0]                   lo_q;
  logic [15:0]                   res_value;
  logic [23:0]                   res_packed;
  logic                          res_full;

  fat12_pkg::tbl_wr_t            wr;
  logic [fat12_pkg::ADDR_W-1:0]  rd_addr;
  logic [fat12_pkg::ENTRY_W-1:0] rd_data;

  logic                          accept;
  logic                          out_free;
  logic                          out_load;
  logic                          alloc_none;
  logic [11:0]                   base_in;
  logic [fat12_pkg::CNT_W-1:0]   base_q;
  logic [fat12_pkg::CNT_W-1:0]   base1_q;
  logic [fat12_pkg::CNT_W-1:0]   lim_in;
  logic [fat12_pkg::CNT_W-1:0]   chk_next;
  logic                          base_oob;
  logic                          base1_oob;
  logic                          idx_oob;
  logic                          link_ok;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_DONE) && out_free;

  // pair base and range checks
  assign base_in   = {entry_index[11:1], 1'b0};
  assign base_q    = {1'b0, idx_q[11:1], 1'b0};
  assign base1_q   = base_q + 13'd1;
  assign base_oob  = (base_q >= fat12_pkg::DEPTH_CNT);
  assign base1_oob = (base1_q >= fat12_pkg::DEPTH_CNT);
  assign idx_oob   = ({1'b0, idx_q} >= fat12_pkg::DEPTH_CNT);
  assign lim_in    = (used_count > fat12_pkg::DEPTH_CNT) ? fat12_pkg::DEPTH_CNT
                                                          : used_count;
  assign alloc_none = (kind == fat12_pkg::KIND_ALLOC) && (lim_in <= fat12_pkg::FIRST_DATA);
  assign chk_next  = chk + 13'd1;
  assign link_ok   = (prev_q >= fat12_pkg::USED_LOW) && (prev_q <= fat12_pkg::USED_HIGH)
                     && (prev_q < {3'b000, lim_q});

  // table read address
  always_comb begin
    rd_addr = base_in[fat12_pkg::ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (kind == fat12_pkg::KIND_ALLOC) begin
          rd_addr = fat12_pkg::FIRST_DATA[fat12_pkg::ADDR_W-1:0];
        end else if (kind == fat12_pkg::KIND_LOOKUP) begin
          rd_addr = entry_index[fat12_pkg::ADDR_W-1:0];
        end else begin
          rd_addr = base_in[fat12_pkg::ADDR_W-1:0];
        end
      end
      S_DUMP1: rd_addr = base1_q[fat12_pkg::ADDR_W-1:0];
      S_SCAN:  rd_addr = chk_next[fat12_pkg::ADDR_W-1:0];
      default: rd_addr = base_in[fat12_pkg::ADDR_W-1:0];
    endcase
  end

  // table write request
  always_comb begin
    wr = '0;
    unique case (state)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr;
        wr.data = '0;
      end
      S_IDLE: begin
        wr.en   = accept && (kind == fat12_pkg::KIND_LOAD)
                  && ({1'b0, base_in} < fat12_pkg::DEPTH_CNT);
        wr.addr = base_in[fat12_pkg::ADDR_W-1:0];
        wr.data = fat12_pkg::widen_entry(packed_in[11:0]);
      end
      S_LOAD2: begin
        wr.en   = !base1_oob;
        wr.addr = base1_q[fat12_pkg::ADDR_W-1:0];
        wr.data = fat12_pkg::widen_entry(hi_q);
      end
      S_SCAN: begin
        wr.en   = (rd_data == '0);
        wr.addr = chk[fat12_pkg::ADDR_W-1:0];
        wr.data = fat12_pkg::END_OF_CHAIN;
      end
      S_LINK: begin
        wr.en   = link_ok;
        wr.addr = prev_q[fat12_pkg::ADDR_W-1:0];
        wr.data = 16'(chk);
      end
      default: wr = '0;
    endcase
  end

  fat12_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer, result and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      used_count <= fat12_pkg::COUNT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        used_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == fat12_pkg::LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            idx_q      <= entry_index;
            prev_q     <= prev_cluster;
            hi_q       <= packed_in[23:12];
            lim_q      <= lim_in;
            chk        <= fat12_pkg::FIRST_DATA;
            res_value  <= alloc_none ? fat12_pkg::END_OF_CHAIN : '0;
            res_packed <= '0;
            res_full   <= alloc_none;
            unique case (kind)
              fat12_pkg::KIND_LOAD:   state <= S_LOAD2;
              fat12_pkg::KIND_LOOKUP: state <= S_LOOK;
              fat12_pkg::KIND_DUMP:   state <= S_DUMP1;
              fat12_pkg::KIND_ALLOC: begin
                if (lim_in <= fat12_pkg::FIRST_DATA) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_LOAD2: state <= S_DONE;
        S_LOOK: begin
          res_value <= idx_oob ? '0 : rd_data;
          state     <= S_DONE;
        end
        S_DUMP1: begin
          lo_q  <= base_oob ? 12'h000 : rd_data[11:0];
          state <= S_DUMP2;
        end
        S_DUMP2: begin
          res_packed <= {(base1_oob ? 12'h000 : rd_data[11:0]), lo_q};
          state      <= S_DONE;
        end
        S_SCAN: begin
          // data for cluster chk arrives this cycle
          if (rd_data == '0) begin
            res_value <= 16'(chk);
            state     <= S_LINK;
          end else if (chk_next >= lim_q) begin
            res_value <= fat12_pkg::END_OF_CHAIN;
            res_full  <= 1'b1;
            state     <= S_DONE;
          end else begin
            chk <= chk_next;
          end
        end
        S_LINK: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            entry_value <= res_value;
            packed_out  <= res_packed;
            table_full  <= res_full;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `FCT_ASSERT_NXT(a_one_item, accept, in_stall, "item taken while another is at work")
  `FCT_ASSERT_IMP(a_full_value, out_valid && table_full, entry_value == fat12_pkg::END_OF_CHAIN, "full without end mark")
  `FCT_ASSERT_IMP(a_exclusive, out_valid, (packed_out == '0) || (entry_value == '0), "value and pair both set")
  `FCT_ASSERT_IMP(a_no_item_in_clear, state == S_CLEAR, !out_valid, "result during clearing pass")

endmodule
